FILE: rtl/itbt_pkg.sv
// Shared constants and helper functions for the signed integer to base text block.
// No dependencies; the core, back end and testbench refer to it by scoped names.
`timescale 1ns / 1ps

package itbt_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int RADIX_W            = 6;
  localparam int CHAR_W             = 7;
  // Dividend bits consumed per divider cycle.
  localparam int DIV_STEP           = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
    logic [RADIX_W-1:0] r;
    if (v < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (v > RADIX_MAX) begin
      r = RADIX_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

FILE: rtl/signed_integer_to_base_text_core.sv
// Top level of the signed integer to base text block: radix register,
// front end with its queue and the divide-and-emit back end. Depends on itbt_pkg.
`timescale 1ns / 1ps

// Each item on the slave stream is a signed integer; the master stream returns its
// text in the current radix (2 to 36), one ASCII character per item, most significant
// first, with tlast on the final character. Negative values lead with '-', zero gives
// "0". Radix writes outside 2..36 are clamped; write it only while the block is idle.
// The back end fetches an item, produces each digit in the shared divider (eight
// dividend bits a cycle), then emits the characters as the master stream takes them.
// A two-item queue lets the next item be accepted while the current one is still
// being converted.
module signed_integer_to_base_text_core #(
  parameter int VALUE_BITS = itbt_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [itbt_pkg::RADIX_W-1:0]       cfg_wr_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // value (bits VALUE_BITS-1:0), zero padding above
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // text_char (bits 6:0), zero padding in bit 7
  output logic [7:0]                         m_tdata,
  output logic                               m_tlast
);

  logic [itbt_pkg::RADIX_W-1:0] radix;
  logic                         q_valid;
  logic                         q_ready;
  logic                         q_neg;
  logic [VALUE_BITS-1:0]        q_mag;
  logic [itbt_pkg::CHAR_W-1:0]  out_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itbt_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= itbt_pkg::clamp_radix(cfg_wr_data);
    end
  end

  itbt_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (s_tdata[VALUE_BITS-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_neg    (q_neg),
    .q_mag    (q_mag)
  );

  itbt_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_neg     (q_neg),
    .q_mag     (q_mag),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

`ifndef SYNTHESIS
  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (radix >= itbt_pkg::RADIX_MIN) && (radix <= itbt_pkg::RADIX_MAX))
    else $error("radix register left the range 2..36 after a write");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[6:0] == itbt_pkg::CHAR_MINUS)) |-> !m_tlast)
    else $error("minus sign marked as the last character");

  a_pop_when_output_done: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> !(m_tvalid && !m_tlast))
    else $error("new item fetched while a number is still being emitted");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready)
    else $error("input not ready after reset");
`endif

endmodule

FILE: rtl/itbt_front.sv
// Front end: accepts input items, splits them into sign and magnitude and
// holds them in a two-entry queue for the back end. Uses itbt_pkg nowhere directly.
`timescale 1ns / 1ps

module itbt_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic                  q_neg,
  output logic [VALUE_BITS-1:0] q_mag
);

  logic                  ent_neg [2];
  logic [VALUE_BITS-1:0] ent_mag [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  pop;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // The magnitude of the most negative value is 2^(VALUE_BITS-1), which still
  // fits the same width when read as unsigned.
  assign neg = in_value[VALUE_BITS-1];
  assign mag = neg ? (~in_value + VALUE_BITS'(1)) : in_value;

  assign q_neg = ent_neg[rd_ptr];
  assign q_mag = ent_mag[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_neg[wr_ptr] <= neg;
      ent_mag[wr_ptr] <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/itbt_back.sv
// Back end: divides the magnitude repeatedly by the radix, stacks the digits
// and emits them most significant first. Depends on itbt_pkg.
`timescale 1ns / 1ps

module itbt_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [itbt_pkg::RADIX_W-1:0]  radix,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic                          q_neg,
  input  logic [VALUE_BITS-1:0]         q_mag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itbt_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);

  localparam int NSTEP   = (VALUE_BITS + itbt_pkg::DIV_STEP - 1) / itbt_pkg::DIV_STEP;
  localparam int MAG_W   = NSTEP * itbt_pkg::DIV_STEP;
  localparam int STEP_W  = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int DEPTH   = VALUE_BITS;
  localparam int DEPTH_W = $clog2(DEPTH + 1);
  localparam int RW      = itbt_pkg::RADIX_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_DIGITS} state_t;

  state_t             state;
  logic [MAG_W-1:0]   work;
  logic [RW-1:0]      rem;
  logic [STEP_W-1:0]  step;
  logic               neg;
  logic [RW-1:0]      stack [DEPTH];
  logic [DEPTH_W-1:0] depth;
  logic [MAG_W-1:0]   work_next;
  logic [RW-1:0]      rem_next;
  logic               out_free;
  logic               emit;

  assign q_ready  = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign emit     = out_free && ((state == S_SIGN) || (state == S_DIGITS));

  // Eight restoring-division steps per cycle: the remainder stays below the
  // radix, so each step needs only a narrow compare and subtract. Quotient
  // bits shift in where dividend bits shift out.
  always_comb begin
    logic [RW:0] r;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < itbt_pkg::DIV_STEP; i++) begin
      r         = {rem_next, work_next[MAG_W-1]};
      work_next = {work_next[MAG_W-2:0], 1'b0};
      if (r >= {1'b0, radix}) begin
        r            = r - {1'b0, radix};
        work_next[0] = 1'b1;
      end
      rem_next = r[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      depth     <= '0;
      step      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            work  <= MAG_W'(q_mag);
            rem   <= '0;
            step  <= '0;
            neg   <= q_neg;
            depth <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == STEP_W'(NSTEP - 1)) begin
            stack[0] <= rem_next;
            for (int i = 1; i < DEPTH; i++) begin
              stack[i] <= stack[i-1];
            end
            depth <= depth + DEPTH_W'(1);
            work  <= work_next;
            rem   <= '0;
            step  <= '0;
            if (work_next == '0) begin
              state <= neg ? S_SIGN : S_DIGITS;
            end
          end else begin
            work <= work_next;
            rem  <= rem_next;
            step <= step + STEP_W'(1);
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char  <= itbt_pkg::CHAR_MINUS;
            out_last  <= 1'b0;
            state     <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (out_free) begin
            out_char  <= itbt_pkg::digit_char(stack[0]);
            out_last  <= (depth == DEPTH_W'(1));
            for (int i = 0; i < DEPTH - 1; i++) begin
              stack[i] <= stack[i+1];
            end
            depth <= depth - DEPTH_W'(1);
            if (depth == DEPTH_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for signed_integer_to_base_text_core: drives signed values over a
// stream, steps the radix register between phases and checks every returned character.
// Depends on itbt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF     = 5;
  localparam int IDLE_SETTLE  = 8;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_PER_PHASE = 25;
  localparam int NUM_PHASES   = 12;

  typedef struct {
    logic [31:0] src;
    logic [7:0]  data;
    logic        last;
  } text_char_t;

  // Holds the text each accepted value should produce, oldest character first.
  class text_scoreboard;
    logic [itbt_pkg::RADIX_W-1:0] radix;
    text_char_t                   expected_q[$];
    int unsigned                  mismatches;
    int unsigned                  values_seen;
    int unsigned                  chars_checked;

    function new();
      radix         = itbt_pkg::RADIX_RESET;
      mismatches    = 0;
      values_seen   = 0;
      chars_checked = 0;
    endfunction

    function void write_radix(input logic [itbt_pkg::RADIX_W-1:0] v);
      if (v < itbt_pkg::RADIX_MIN) begin
        radix = itbt_pkg::RADIX_MIN;
      end else if (v > itbt_pkg::RADIX_MAX) begin
        radix = itbt_pkg::RADIX_MAX;
      end else begin
        radix = v;
      end
    endfunction

    function int chars_outstanding();
      return expected_q.size();
    endfunction

    // Repeated division gives the digits least significant first; they are queued in
    // reverse. The magnitude fits 32 unsigned bits, the most negative value included.
    function void note_value(input logic [31:0] v);
      logic [31:0] mag;
      logic [31:0] base;
      logic [5:0]  digits[0:32];
      int          nd;
      text_char_t  c;
      mag  = v[31] ? (32'd0 - v) : v;
      base = {26'd0, radix};
      nd   = 0;
      do begin
        digits[nd] = 6'(mag % base);
        mag = mag / base;
        nd++;
      end while (mag != 0);
      c.src = v;
      if (v[31]) begin
        c.data = {1'b0, itbt_pkg::CHAR_MINUS};
        c.last = 1'b0;
        expected_q.push_back(c);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        if (digits[k] < 6'd10) begin
          c.data = {1'b0, itbt_pkg::CHAR_ZERO + 7'(digits[k])};
        end else begin
          c.data = {1'b0, itbt_pkg::CHAR_A + 7'(digits[k] - 6'd10)};
        end
        c.last = (k == 0);
        expected_q.push_back(c);
      end
      values_seen++;
    endfunction

    function void check_char(input logic [7:0] data, input logic last);
      text_char_t e;
      chars_checked++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected character 0x%02h last %0b", $realtime, data, last);
        end
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        if (data !== e.data || last !== e.last) begin
          if (mismatches < 10) begin
            $display("%0t: value %0d radix %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
                     $realtime, $signed(e.src), radix, e.data, e.last, data, last);
          end
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [itbt_pkg::RADIX_W-1:0] cfg_wr_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [31:0]                  s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [7:0]                   m_tdata;
  logic                         m_tlast;

  text_scoreboard sb;
  bit             quiet = 1'b0;
  int unsigned    settings_used = 1;

  signed_integer_to_base_text_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [31:0] pick_value(input int unsigned base);
    int unsigned     sel;
    int unsigned     k;
    longint unsigned p;
    logic [31:0]     v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom >> $urandom_range(1, 31);
      5:       v = $urandom_range(0, 2 * base);
      6, 7: begin
        // Powers of the base and one below them change the digit count.
        p = 1;
        k = $urandom_range(1, 31);
        while (k != 0 && p * base <= 64'h7fff_ffff) begin
          p = p * base;
          k--;
        end
        v = p[31:0] - $urandom_range(0, 1);
      end
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'hffff_ffff;
          default: v = 32'h0000_0000;
        endcase
      end
      default: begin
        v = $urandom;
        v[31:8] = {24{v[31]}};
      end
    endcase
    if (sel >= 3 && sel <= 7 && $urandom_range(0, 1) == 1) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_value(v);
  endtask

  task automatic send_gapped(input logic [31:0] v);
    int unsigned gap;
    send_value(v);
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.chars_outstanding() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_radix(input logic [itbt_pkg::RADIX_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_radix(v);
    settings_used++;
  endtask

  // Result side: check at each accepted edge, then choose the next ready level.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_char(m_tdata, m_tlast);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    logic [31:0]                  reset_set[] = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10,
                                                  32'hffff_fff6, 32'd99, 32'h7fff_ffff,
                                                  32'h8000_0000, 32'd12345};
    logic [31:0]                  binary_set[] = '{32'h8000_0000, 32'h7fff_ffff,
                                                   32'hffff_ffff, 32'd0, 32'h5555_5555};
    logic [31:0]                  base36_set[] = '{32'd35, 32'hffff_ffdd, 32'd36,
                                                   32'h8000_0000, 32'h7fff_ffff};
    logic [itbt_pkg::RADIX_W-1:0] radix_plan[NUM_PHASES] = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1,
                                                             6'd37, 6'd16, 6'd8, 6'd3, 6'd10,
                                                             6'd35, 6'd21};
    int unsigned                  leftover;

    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset radix first, without any write.
    foreach (reset_set[i]) send_gapped(reset_set[i]);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_gapped(pick_value(sb.radix));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      quiet = (ph == 4 || ph == 9);
      write_radix(radix_plan[ph]);
      if (radix_plan[ph] == 6'd2) begin
        foreach (binary_set[i]) send_gapped(binary_set[i]);
      end else if (radix_plan[ph] == 6'd36) begin
        foreach (base36_set[i]) send_gapped(base36_set[i]);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // Hold the sender once mid-phase until all text has come back.
        if (ph == 6 && i == RANDOM_PER_PHASE / 2) begin
          wait_idle();
        end
        send_gapped(pick_value(sb.radix));
      end
    end

    quiet = 1'b0;
    s_tvalid <= 1'b0;
    while (sb.chars_outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    leftover = sb.chars_outstanding();
    if (leftover != 0) begin
      $display("%0d expected characters never arrived", leftover);
    end
    $display("summary: %0d values converted, %0d characters checked, %0d radix settings",
             sb.values_seen, sb.chars_checked, settings_used);
    $display("summary: bases 2 to 36 incl. clamped writes, extremes, zero and minus signs");
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d characters outstanding", sb.chars_outstanding());
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: signed_integer_to_base_text_core.f
rtl/itbt_pkg.sv
rtl/itbt_front.sv
rtl/itbt_back.sv
rtl/signed_integer_to_base_text_core.sv
dv/tb.sv
